### rtl/core/stt_pkg.sv
// Package for the software timer table: request/response beat types and constants.
// No dependencies.
`timescale 1ns / 1ps
package stt_pkg;

   localparam logic [1:0] REQ_CREATE = 2'd0;
   localparam logic [1:0] REQ_TICK   = 2'd1;
   localparam logic [1:0] REQ_CANCEL = 2'd2;

   localparam logic [31:0] SHIFT_DOWN = 32'hFFFF_FFFE - 32'd999;
   localparam logic [31:0] UNLIMITED  = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [31:0] interval;
      logic [31:0] repeat_count;
      logic [15:0] callback_id;
      logic [31:0] extra_word;
      logic [15:0] owner_task;
      logic [3:0]  cancel_slot;
   } req_type_type;

   typedef struct packed {
      logic        fired;
      logic [3:0]  fired_slot;
      logic [15:0] fired_callback;
      logic [31:0] fired_extra;
      logic [15:0] fired_owner;
      logic        accepted;
      logic [4:0]  entry_count;
   } rsp_type_type;

   // one table entry as stored in memory
   typedef struct packed {
      logic [31:0] interval;
      logic [31:0] remaining;
      logic [31:0] due;
      logic [15:0] callback;
      logic [31:0] extra;
      logic [15:0] owner;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

### rtl/core/stt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module stt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

### rtl/core/software_timer_table.sv
// Top level of the software timer table: control sequencer around one entry RAM.
// Depends on stt_pkg and stt_ram.
`timescale 1ns / 1ps
// Usage:
//   req_* carries one request beat (create, tick or cancel); rsp_* returns exactly
//   one response beat per request. The block handles one request at a time.
//   Create: one write into the entry RAM unless the table is full, then the response.
//   Cancel: shifts the later entries down one place, one read and one write each.
//   Tick: walks the table from position 0, reading each entry; only an entry
//   that is due is written back, and the first due entry ends the walk. Each
//   visited entry takes a read and a write state. A removed entry also costs
//   a compaction pass over the entries behind it. Near the top of the count
//   range the tick first lowers every due time, one pass over all entries
//   below the entry count.
//   The entry RAM port (one read, one write per cycle) sets the pace.
//   Reset clears the tick count and the entry count; the RAM is not cleared,
//   since only positions below the entry count are ever used.
//   The response sits in an output register; a stalled receiver holds it and
//   the block takes no new request until it is taken. req_ready is high only
//   when the sequencer is idle and the output register is empty.
module software_timer_table #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  stt_pkg::req_type_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output stt_pkg::rsp_type_type rsp_data
);
   import stt_pkg::*;

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

   typedef enum logic [3:0] {
      ST_IDLE, ST_SHIFT_RD, ST_SHIFT_WR, ST_SCAN_RD, ST_SCAN_WR,
      ST_MOVE_RD, ST_MOVE_WR, ST_DONE
   } state_type;

   state_type      state_ff;
   logic [31:0]    tick_ff;
   logic [CW-1:0]  total_ff;
   logic [CW-1:0]  idx_ff;     // current position of the scan or shift
   logic [CW-1:0]  mov_ff;     // destination of a compaction move
   logic           mov_scan_ff; // compaction belongs to a tick scan
   logic           rsp_valid_ff;
   rsp_type_type   rsp_ff;
   rsp_type_type   rsp_in;

   logic           wr_en;
   logic [AW-1:0]  wr_addr, rd_addr;
   entry_type      wr_data, rd_data;

   stt_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   logic [31:0] tick_inc;
   logic        live;
   logic        slot_used;
   logic        req_ok;
   assign tick_inc = tick_ff + 32'd1;
   assign live = (rd_data.remaining == UNLIMITED) ||
                 (rd_data.remaining != 32'd0 && !rd_data.remaining[31]);
   assign slot_used = 32'(req_data.cancel_slot) < 32'(total_ff);
   // accepted flag of the incoming beat
   assign req_ok = (req_data.req_type == REQ_CREATE && total_ff < DEPTH_C) ||
                   (req_data.req_type == REQ_TICK) ||
                   (req_data.req_type == REQ_CANCEL && slot_used);

   assign req_ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // RAM port control
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = idx_ff[AW-1:0];
      wr_data = rd_data;
      rd_addr = idx_ff[AW-1:0];
      case (state_ff)
         ST_IDLE: begin
            wr_addr = total_ff[AW-1:0];
            wr_data.interval  = req_data.interval;
            wr_data.remaining = req_data.repeat_count;
            wr_data.due       = tick_ff + req_data.interval - 32'd1;
            wr_data.callback  = req_data.callback_id;
            wr_data.extra     = req_data.extra_word;
            wr_data.owner     = req_data.owner_task;
            wr_en = req_valid && req_ready && req_data.req_type == REQ_CREATE &&
                    total_ff < DEPTH_C;
         end
         ST_SHIFT_WR: begin
            wr_en = 1'b1;
            wr_data.due = rd_data.due - SHIFT_DOWN;
         end
         ST_SCAN_WR: begin
            wr_en = live && (tick_ff > rd_data.due);
            if (rd_data.remaining != UNLIMITED) begin
               wr_data.remaining = rd_data.remaining - 32'd1;
            end
            wr_data.due = rd_data.due + rd_data.interval;
         end
         ST_MOVE_RD: begin
            rd_addr = AW'(mov_ff + CW'(1));
         end
         ST_MOVE_WR: begin
            wr_en   = 1'b1;
            wr_addr = mov_ff[AW-1:0];
         end
         default: ;
      endcase
   end

   // response register: clear on a new beat, fill on a firing, count at the end
   always_comb begin
      rsp_in = rsp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               rsp_in = '0;
               rsp_in.accepted = req_ok;
            end
         end
         ST_SCAN_WR: begin
            if (live && (tick_ff > rd_data.due)) begin
               rsp_in.fired          = 1'b1;
               rsp_in.fired_slot     = 4'(idx_ff);
               rsp_in.fired_callback = rd_data.callback;
               rsp_in.fired_extra    = rd_data.extra;
               rsp_in.fired_owner    = rd_data.owner;
            end
         end
         ST_DONE: begin
            rsp_in.entry_count = 5'(total_ff);
         end
         default: ;
      endcase
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tick_ff      <= '0;
         total_ff     <= '0;
         idx_ff       <= '0;
         mov_ff       <= '0;
         mov_scan_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_ff       <= '0;
      end else begin
         rsp_ff <= rsp_in;
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid && req_ready) begin
                  idx_ff <= '0;
                  case (req_data.req_type)
                     REQ_CREATE: begin
                        if (total_ff < DEPTH_C) begin
                           total_ff <= total_ff + CW'(1);
                        end
                        state_ff <= ST_DONE;
                     end
                     REQ_TICK: begin
                        if (tick_inc > SHIFT_DOWN) begin
                           tick_ff  <= tick_inc - SHIFT_DOWN;
                           state_ff <= ST_SHIFT_RD;
                        end else begin
                           tick_ff  <= tick_inc;
                           state_ff <= ST_SCAN_RD;
                        end
                     end
                     REQ_CANCEL: begin
                        if (slot_used) begin
                           mov_ff      <= CW'(req_data.cancel_slot);
                           mov_scan_ff <= 1'b0;
                           state_ff    <= ST_MOVE_RD;
                        end else begin
                           state_ff <= ST_DONE;
                        end
                     end
                     default: state_ff <= ST_DONE;
                  endcase
               end
            end
            ST_SHIFT_RD: begin
               // lower every due time, one entry per visit
               state_ff <= (idx_ff < total_ff) ? ST_SHIFT_WR : ST_SCAN_RD;
               if (idx_ff >= total_ff) begin
                  idx_ff <= '0;
               end
            end
            ST_SHIFT_WR: begin
               idx_ff   <= idx_ff + CW'(1);
               state_ff <= ST_SHIFT_RD;
            end
            ST_SCAN_RD: begin
               state_ff <= (idx_ff < total_ff) ? ST_SCAN_WR : ST_DONE;
            end
            ST_SCAN_WR: begin
               if (!live) begin
                  // drop: compact the tail over this position
                  mov_ff      <= idx_ff;
                  mov_scan_ff <= 1'b1;
                  state_ff    <= ST_MOVE_RD;
               end else if (tick_ff > rd_data.due) begin
                  state_ff <= ST_DONE;
               end else begin
                  idx_ff   <= idx_ff + CW'(1);
                  state_ff <= ST_SCAN_RD;
               end
            end
            ST_MOVE_RD: begin
               if (mov_ff + CW'(1) < total_ff) begin
                  state_ff <= ST_MOVE_WR;
               end else begin
                  total_ff <= total_ff - CW'(1);
                  state_ff <= mov_scan_ff ? ST_SCAN_RD : ST_DONE;
               end
            end
            ST_MOVE_WR: begin
               mov_ff   <= mov_ff + CW'(1);
               state_ff <= ST_MOVE_RD;
            end
            ST_DONE: begin
               rsp_valid_ff <= 1'b1;
               state_ff     <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule
